// ===== rtl/hkve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_pkg: shared types and constants for the hid key escape encoder
// key table, character codes, modifier masks and register map
// ----------------------------------------------------------------------------
package hkve_pkg;

   // default depth of a sequence buffer, in bytes
   localparam int SEQ_BUF_LEN_DEF = 8;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // every emitted sequence has at least esc, introducer and final byte
   localparam int MIN_SEQ_LEN = 3;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // character codes
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_SS3    = 8'h4F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;

   // left and right modifier masks
   localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
   localparam logic [7:0] MOD_ALT_MASK   = 8'h44;
   localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;

   // register index, taken from address bit 2
   typedef enum logic {
      REG_APP_CURSOR = 1'b0,
      REG_MAX_SEQ    = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_TILDE = 2'd1,
      KIND_APP   = 2'd2,
      KIND_SS3   = 2'd3
   } key_kind_type;

   typedef struct packed {
      key_kind_type kind;
      logic [7:0]   code;
   } key_entry_type;

   typedef struct packed {
      logic       app_cursor_mode;
      logic [2:0] max_seq_len;
   } cfg_type;

   // usage code to key entry; anything not listed is no key
   function automatic key_entry_type key_lookup(input logic [7:0] usage);
      key_entry_type e;
      e.kind = KIND_NONE;
      e.code = 8'd0;
      unique case (usage)
         8'h3A: begin e.kind = KIND_SS3;   e.code = 8'h50; end // F1 'P'
         8'h3B: begin e.kind = KIND_SS3;   e.code = 8'h51; end // F2 'Q'
         8'h3C: begin e.kind = KIND_SS3;   e.code = 8'h52; end // F3 'R'
         8'h3D: begin e.kind = KIND_SS3;   e.code = 8'h53; end // F4 'S'
         8'h3E: begin e.kind = KIND_TILDE; e.code = 8'd15; end
         8'h3F: begin e.kind = KIND_TILDE; e.code = 8'd17; end
         8'h40: begin e.kind = KIND_TILDE; e.code = 8'd18; end
         8'h41: begin e.kind = KIND_TILDE; e.code = 8'd19; end
         8'h42: begin e.kind = KIND_TILDE; e.code = 8'd20; end
         8'h43: begin e.kind = KIND_TILDE; e.code = 8'd21; end
         8'h44: begin e.kind = KIND_TILDE; e.code = 8'd23; end
         8'h45: begin e.kind = KIND_TILDE; e.code = 8'd24; end
         8'h49: begin e.kind = KIND_TILDE; e.code = 8'd2;  end // insert
         8'h4A: begin e.kind = KIND_APP;   e.code = 8'h48; end // home 'H'
         8'h4B: begin e.kind = KIND_TILDE; e.code = 8'd5;  end // page up
         8'h4C: begin e.kind = KIND_TILDE; e.code = 8'd3;  end // delete
         8'h4D: begin e.kind = KIND_APP;   e.code = 8'h46; end // end 'F'
         8'h4E: begin e.kind = KIND_TILDE; e.code = 8'd6;  end // page down
         8'h4F: begin e.kind = KIND_APP;   e.code = 8'h43; end // right 'C'
         8'h50: begin e.kind = KIND_APP;   e.code = 8'h44; end // left 'D'
         8'h51: begin e.kind = KIND_APP;   e.code = 8'h42; end // down 'B'
         8'h52: begin e.kind = KIND_APP;   e.code = 8'h41; end // up 'A'
         default: begin e.kind = KIND_NONE; e.code = 8'd0; end
      endcase
      return e;
   endfunction

   // tens digit of a tilde code (codes stay below 30)
   function automatic logic [1:0] dec_tens(input logic [4:0] v);
      logic [1:0] t;
      if (v >= 5'd20) t = 2'd2;
      else if (v >= 5'd10) t = 2'd1;
      else t = 2'd0;
      return t;
   endfunction

   // ones digit of a tilde code
   function automatic logic [3:0] dec_ones(input logic [4:0] v);
      logic [4:0] r;
      if (v >= 5'd20) r = v - 5'd20;
      else if (v >= 5'd10) r = v - 5'd10;
      else r = v;
      return r[3:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hkve_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_req_if: key beat channel
// valid/ready channel carrying one hid usage and modifier byte per beat
// ----------------------------------------------------------------------------
interface hkve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hid_usage;
   logic [7:0] hid_modifiers;

   modport source (output valid, output hid_usage, output hid_modifiers, input ready);
   modport sink   (input valid, input hid_usage, input hid_modifiers, output ready);
endinterface
`default_nettype wire

// ===== rtl/hkve_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_rsp_if: escape byte channel
// valid/ready channel carrying one sequence byte and its last flag per beat
// ----------------------------------------------------------------------------
interface hkve_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source (output valid, output out_byte, output last_byte, input ready);
   modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/hid_key_to_vt_escape_encoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_key_to_vt_escape_encoder: hid key to xterm escape sequence encoder
// maps navigation and function keys with modifiers to escape byte streams
//
//   channel   dir   beat contents                     handshake
//   req_bus   in    hid_usage, hid_modifiers          valid/ready
//   rsp_bus   out   out_byte, last_byte               valid/ready
//   csr_*     in    app_cursor_mode, max_seq_len      apb, pready high
//
// a key is built in the cycle it is accepted; its sequence leaves one byte
// per cycle while rsp_bus is ready, sequences are 3 to 7 bytes long, and
// the serializer sets the sustained rate
// the two-entry sequence queue lets keys be taken while bytes are stalled
// unknown and over-long keys are accepted but give no bytes
// reset is synchronous; it empties the queue and sets registers to defaults
// ----------------------------------------------------------------------------
module hid_key_to_vt_escape_encoder
   import hkve_pkg::*;
#(
   parameter int SEQ_BUF_LEN = SEQ_BUF_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   hkve_req_if.sink              req_bus,
   hkve_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int LEN_W = $clog2(SEQ_BUF_LEN + 1);
   localparam int Q_W   = SEQ_BUF_LEN * 8 + LEN_W;

   logic                     cursor_mode_ff, cursor_mode_in;
   logic [2:0]               max_seq_ff, max_seq_in;
   logic                     csr_write;
   csr_reg_type              csr_reg;
   cfg_type                  cfg;
   logic                     q_push, q_pop, q_full, q_empty;
   logic [SEQ_BUF_LEN*8-1:0] push_bytes, pop_bytes;
   logic [LEN_W-1:0]         push_len, pop_len;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      cursor_mode_in = cursor_mode_ff;
      max_seq_in     = max_seq_ff;
      if (csr_write) begin
         unique case (csr_reg)
            REG_APP_CURSOR: cursor_mode_in = csr_pwdata[0];
            REG_MAX_SEQ:    max_seq_in     = csr_pwdata[2:0];
            default:        cursor_mode_in = cursor_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_mode_ff <= 1'b0;
         max_seq_ff     <= 3'd7;
      end else begin
         cursor_mode_ff <= cursor_mode_in;
         max_seq_ff     <= max_seq_in;
      end
   end

   // register read back
   always_comb begin
      unique case (csr_reg)
         REG_APP_CURSOR: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cursor_mode_ff};
         REG_MAX_SEQ:    csr_prdata = {{(CSR_DATA_W-3){1'b0}}, max_seq_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg.app_cursor_mode = cursor_mode_ff;
   assign cfg.max_seq_len     = max_seq_ff;

   // front: classify and build
   hkve_front #(.SEQ_BUF_LEN(SEQ_BUF_LEN)) u_front (
      .req_bus (req_bus),
      .cfg     (cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_bytes (push_bytes),
      .q_len   (push_len)
   );

   // queue of whole sequences
   hkve_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_len, push_bytes}),
      .pop       (q_pop),
      .pop_data  ({pop_len, pop_bytes}),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: serialize bytes
   hkve_back #(.SEQ_BUF_LEN(SEQ_BUF_LEN)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_bytes (pop_bytes),
      .q_len   (pop_len),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== rtl/hkve_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_front: key classifier and sequence builder
// looks up the key, folds modifiers, builds the whole sequence and pushes it
// ----------------------------------------------------------------------------
module hkve_front
   import hkve_pkg::*;
#(
   parameter int SEQ_BUF_LEN = SEQ_BUF_LEN_DEF,
   localparam int LEN_W = $clog2(SEQ_BUF_LEN + 1),
   localparam int IDX_W = $clog2(SEQ_BUF_LEN)
) (
   hkve_req_if.sink                 req_bus,
   input  cfg_type                  cfg,
   input  logic                     q_full,
   output logic                     q_push,
   output logic [SEQ_BUF_LEN*8-1:0] q_bytes,
   output logic [LEN_W-1:0]         q_len
);

   key_entry_type          key;
   logic [2:0]             mods;
   logic [3:0]             m_val;
   logic [1:0]             tens;
   logic [3:0]             ones;
   logic [7:0]             seq_c [SEQ_BUF_LEN];
   logic [LEN_W-1:0]       pos_c;

   // take a key whenever the queue has room
   assign req_bus.ready = !q_full;

   // classify
   assign key  = key_lookup(req_bus.hid_usage);
   assign mods = {|(req_bus.hid_modifiers & MOD_CTRL_MASK),
                  |(req_bus.hid_modifiers & MOD_ALT_MASK),
                  |(req_bus.hid_modifiers & MOD_SHIFT_MASK)};
   assign m_val = {1'b0, mods} + 4'd1;
   assign tens  = dec_tens(key.code[4:0]);
   assign ones  = dec_ones(key.code[4:0]);

   // build the sequence bytes and count them
   always_comb begin
      for (int i = 0; i < SEQ_BUF_LEN; i++) seq_c[i] = 8'd0;
      pos_c = '0;
      seq_c[pos_c[IDX_W-1:0]] = CH_ESC;
      pos_c = pos_c + LEN_W'(1);
      if (mods == 3'd0) begin
         if (key.kind == KIND_TILDE) begin
            seq_c[pos_c[IDX_W-1:0]] = CH_LBRACK;
            pos_c = pos_c + LEN_W'(1);
            if (tens != 2'd0) begin
               seq_c[pos_c[IDX_W-1:0]] = CH_ZERO + {6'd0, tens};
               pos_c = pos_c + LEN_W'(1);
            end
            seq_c[pos_c[IDX_W-1:0]] = CH_ZERO + {4'd0, ones};
            pos_c = pos_c + LEN_W'(1);
            seq_c[pos_c[IDX_W-1:0]] = CH_TILDE;
            pos_c = pos_c + LEN_W'(1);
         end else begin
            if (key.kind == KIND_SS3 || (key.kind == KIND_APP && cfg.app_cursor_mode)) begin
               seq_c[pos_c[IDX_W-1:0]] = CH_SS3;
            end else begin
               seq_c[pos_c[IDX_W-1:0]] = CH_LBRACK;
            end
            pos_c = pos_c + LEN_W'(1);
            seq_c[pos_c[IDX_W-1:0]] = key.code;
            pos_c = pos_c + LEN_W'(1);
         end
      end else begin
         seq_c[pos_c[IDX_W-1:0]] = CH_LBRACK;
         pos_c = pos_c + LEN_W'(1);
         if (key.kind == KIND_TILDE) begin
            if (tens != 2'd0) begin
               seq_c[pos_c[IDX_W-1:0]] = CH_ZERO + {6'd0, tens};
               pos_c = pos_c + LEN_W'(1);
            end
            seq_c[pos_c[IDX_W-1:0]] = CH_ZERO + {4'd0, ones};
         end else begin
            seq_c[pos_c[IDX_W-1:0]] = CH_ONE;
         end
         pos_c = pos_c + LEN_W'(1);
         seq_c[pos_c[IDX_W-1:0]] = CH_SEMI;
         pos_c = pos_c + LEN_W'(1);
         seq_c[pos_c[IDX_W-1:0]] = CH_ZERO + {4'd0, m_val};
         pos_c = pos_c + LEN_W'(1);
         seq_c[pos_c[IDX_W-1:0]] = (key.kind == KIND_TILDE) ? CH_TILDE : key.code;
         pos_c = pos_c + LEN_W'(1);
      end
   end

   // pack for the queue
   always_comb begin
      for (int i = 0; i < SEQ_BUF_LEN; i++) q_bytes[i*8 +: 8] = seq_c[i];
   end
   assign q_len = pos_c;

   // unknown keys and over-long sequences leave nothing behind
   assign q_push = req_bus.valid && !q_full && (key.kind != KIND_NONE) &&
                   (pos_c <= LEN_W'(cfg.max_seq_len));

endmodule
`default_nettype wire

// ===== rtl/hkve_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_queue: sequence queue
// small fifo of whole sequences between the builder and the serializer
// ----------------------------------------------------------------------------
module hkve_queue
   import hkve_pkg::*;
#(
   parameter int WIDTH = SEQ_BUF_LEN_DEF * 8 + 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

// ===== rtl/hkve_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hkve_back: sequence serializer
// holds one sequence and sends it a byte per beat, flagging the last byte
// ----------------------------------------------------------------------------
module hkve_back
   import hkve_pkg::*;
#(
   parameter int SEQ_BUF_LEN = SEQ_BUF_LEN_DEF,
   localparam int LEN_W = $clog2(SEQ_BUF_LEN + 1),
   localparam int IDX_W = $clog2(SEQ_BUF_LEN)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  logic [SEQ_BUF_LEN*8-1:0] q_bytes,
   input  logic [LEN_W-1:0]         q_len,
   output logic                     q_pop,
   hkve_rsp_if.source               rsp_bus
);

   logic [SEQ_BUF_LEN*8-1:0] bytes_ff, bytes_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     busy_ff, busy_in;
   logic                     beat, is_last;

   // output comes straight from the held sequence
   assign is_last           = (LEN_W'(idx_ff) + LEN_W'(1)) == len_ff;
   assign rsp_bus.valid     = busy_ff;
   assign rsp_bus.out_byte  = bytes_ff[idx_ff*8 +: 8];
   assign rsp_bus.last_byte = is_last;
   assign beat              = busy_ff && rsp_bus.ready;

   // load the next sequence when idle or as the last byte leaves
   assign q_pop = !q_empty && (!busy_ff || (beat && is_last));

   always_comb begin
      bytes_in = bytes_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (!busy_ff || (beat && is_last)) begin
         busy_in  = !q_empty;
         bytes_in = q_bytes;
         len_in   = q_len;
         idx_in   = '0;
      end else if (beat) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      len_ff   <= len_in;
   end

`ifndef SYNTHESIS
   // byte index stays inside the held sequence
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (LEN_W'(idx_ff) < len_ff))
      else $error("byte index past end of sequence");

   // held sequences are never shorter than the minimum form
   a_len_min: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (len_ff >= LEN_W'(MIN_SEQ_LEN)))
      else $error("sequence shorter than minimum");

   // a middle byte taken moves to the next byte of the same sequence
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (beat && !is_last) |=> (busy_ff && idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("serializer did not advance");

   // a stalled byte holds its place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_bus.ready) |=> (busy_ff && $stable(idx_ff)))
      else $error("serializer moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/hkve_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkve_tb_pkg: escape sequence scoreboard for the hid key encoder bench
// builds the expected xterm byte stream for every key taken by the block,
// keeps its own copy of the cursor mode and length limit, and checks every
// byte beat against the oldest byte still due
// ----------------------------------------------------------------------------
package hkve_tb_pkg;
   import hkve_pkg::*;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } esc_beat_type;

   class escape_seq_scoreboard;
      bit             cursor_mode;
      logic [2:0]     max_len;
      esc_beat_type   pending_beats[$];
      logic [7:0]     seq_bytes[$];
      int unsigned    errors;
      int unsigned    keys_seen;
      int unsigned    silent_keys;
      int unsigned    bytes_checked;

      function new();
         cursor_mode   = 1'b0;
         max_len       = 3'd7;
         errors        = 0;
         keys_seen     = 0;
         silent_keys   = 0;
         bytes_checked = 0;
      endfunction

      function void set_register(input csr_reg_type idx, input logic [31:0] value);
         case (idx)
            REG_APP_CURSOR: cursor_mode = value[0];
            REG_MAX_SEQ:    max_len     = value[2:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending_count();
         return pending_beats.size();
      endfunction

      // navigation and function key table; anything else is no key
      function void decode_key(input logic [7:0] usage,
                               output key_kind_type kind, output logic [7:0] code);
         kind = KIND_TILDE;
         code = 8'd0;
         case (usage)
            8'h3A: begin kind = KIND_SS3; code = "P"; end
            8'h3B: begin kind = KIND_SS3; code = "Q"; end
            8'h3C: begin kind = KIND_SS3; code = "R"; end
            8'h3D: begin kind = KIND_SS3; code = "S"; end
            8'h3E: code = 8'd15;
            8'h3F: code = 8'd17;
            8'h40: code = 8'd18;
            8'h41: code = 8'd19;
            8'h42: code = 8'd20;
            8'h43: code = 8'd21;
            8'h44: code = 8'd23;
            8'h45: code = 8'd24;
            8'h49: code = 8'd2;
            8'h4A: begin kind = KIND_APP; code = "H"; end
            8'h4B: code = 8'd5;
            8'h4C: code = 8'd3;
            8'h4D: begin kind = KIND_APP; code = "F"; end
            8'h4E: code = 8'd6;
            8'h4F: begin kind = KIND_APP; code = "C"; end
            8'h50: begin kind = KIND_APP; code = "D"; end
            8'h51: begin kind = KIND_APP; code = "B"; end
            8'h52: begin kind = KIND_APP; code = "A"; end
            default: kind = KIND_NONE;
         endcase
      endfunction

      // one or two ascii digits
      function void add_decimal(input int unsigned v);
         if (v >= 10) seq_bytes.push_back(CH_ZERO + 8'(v / 10));
         seq_bytes.push_back(CH_ZERO + 8'(v % 10));
      endfunction

      // expected bytes of one accepted key
      function void note_key(input logic [7:0] usage, input logic [7:0] hmods);
         key_kind_type kind;
         logic [7:0]   code;
         int unsigned  mods;
         esc_beat_type beat;
         keys_seen++;
         seq_bytes.delete();
         decode_key(usage, kind, code);
         if (kind != KIND_NONE) begin
            // fold left and right copies, gui dropped
            mods = 0;
            if ((hmods & MOD_SHIFT_MASK) != 0) mods |= 1;
            if ((hmods & MOD_ALT_MASK) != 0)   mods |= 2;
            if ((hmods & MOD_CTRL_MASK) != 0)  mods |= 4;
            seq_bytes.push_back(CH_ESC);
            if (mods == 0) begin
               if (kind == KIND_TILDE) begin
                  seq_bytes.push_back(CH_LBRACK);
                  add_decimal(code);
                  seq_bytes.push_back(CH_TILDE);
               end else begin
                  if (kind == KIND_SS3 || (kind == KIND_APP && cursor_mode))
                     seq_bytes.push_back(CH_SS3);
                  else
                     seq_bytes.push_back(CH_LBRACK);
                  seq_bytes.push_back(code);
               end
            end else begin
               seq_bytes.push_back(CH_LBRACK);
               add_decimal(kind == KIND_TILDE ? code : 1);
               seq_bytes.push_back(CH_SEMI);
               add_decimal(1 + mods);
               seq_bytes.push_back(kind == KIND_TILDE ? CH_TILDE : code);
            end
         end
         // over-long sequences vanish whole
         if (seq_bytes.size() == 0 || seq_bytes.size() > max_len) begin
            silent_keys++;
         end else begin
            foreach (seq_bytes[i]) begin
               beat.out_byte  = seq_bytes[i];
               beat.last_byte = (i == seq_bytes.size() - 1);
               pending_beats.push_back(beat);
            end
         end
      endfunction

      // compare one byte beat with the oldest byte due
      function void check_byte(input logic [7:0] out_byte, input logic last_byte);
         esc_beat_type due;
         if (pending_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual byte %h last %b",
                     $time, out_byte, last_byte);
         end else begin
            due = pending_beats.pop_front();
            bytes_checked++;
            if (due.out_byte !== out_byte) begin
               errors++;
               $display("%0t: out_byte mismatch, expected %h, actual %h",
                        $time, due.out_byte, out_byte);
            end
            if (due.last_byte !== last_byte) begin
               errors++;
               $display("%0t: last_byte mismatch, expected %b, actual %b",
                        $time, due.last_byte, last_byte);
            end
         end
      endfunction
   endclass

endpackage

// ===== tb/hid_key_to_vt_escape_encoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_key_to_vt_escape_encoder_tb: bench for the hid key escape encoder
// directed keys cover every key form, modifier folding, gui-only and unknown
// usages; random phases then sweep cursor mode and length limit with random
// gaps and stalls on both channels, every byte beat checked against the
// scoreboard
// ----------------------------------------------------------------------------
module hid_key_to_vt_escape_encoder_tb;
   import hkve_pkg::*;
   import hkve_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 12;
   localparam int PHASE_KEYS   = 50;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit          calm;
   int unsigned rsp_hold;
   int unsigned cycle_count;
   int unsigned config_writes;

   escape_seq_scoreboard sb = new();

   hkve_req_if req_if();
   hkve_rsp_if rsp_if();

   hid_key_to_vt_escape_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // mostly short idles, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // byte sink stalls
   always @(negedge clock) begin
      if (calm) begin
         rsp_if.ready = 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
      end else if (rsp_if.ready) begin
         rsp_if.ready = 1'b0;
         rsp_hold = idle_len();
      end else begin
         rsp_if.ready = 1'b1;
         rsp_hold = $urandom_range(0, 10);
      end
   end

   // byte beat monitor
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_byte(rsp_if.out_byte, rsp_if.last_byte);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // one key beat, then a random gap
   task automatic send_key(input logic [7:0] usage, input logic [7:0] mods);
      int unsigned gap;
      @(negedge clock);
      req_if.valid         = 1'b1;
      req_if.hid_usage     = usage;
      req_if.hid_modifiers = mods;
      do @(posedge clock); while (!req_if.ready);
      sb.note_key(usage, mods);
      gap = calm ? 0 : idle_len();
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and let every due byte drain
   task automatic wait_drained();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // apb write then read back
   task automatic csr_write(input csr_reg_type idx, input logic [31:0] value);
      logic [31:0] readback;
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(idx, value);
      config_writes++;
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (readback !== value) begin
         sb.errors++;
         $display("%0t: register %0d readback mismatch, expected %h, actual %h",
                  $time, idx, value, readback);
      end
   endtask

   // mostly table keys, some boundary and arbitrary usages
   task automatic pick_key(output logic [7:0] usage, output logic [7:0] mods);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) usage = 8'h3A + 8'($urandom_range(0, 24));
      else if (r < 85) usage = $urandom_range(0, 1) ? 8'h39 : 8'h53;
      else usage = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 30) mods = 8'h00;
      else if (r < 50) mods = 8'h01 << $urandom_range(0, 7);
      else if (r < 60) mods = 8'($urandom_range(1, 3)) == 8'd1 ? 8'h08 :
                              ($urandom_range(0, 1) ? 8'h80 : 8'h88);
      else mods = 8'($urandom_range(0, 255));
   endtask

   // one setting of the registers, then random keys
   task automatic run_phase(input bit app, input int unsigned limit, input int unsigned keys);
      logic [7:0] usage;
      logic [7:0] mods;
      wait_drained();
      csr_write(REG_APP_CURSOR, {31'd0, app});
      csr_write(REG_MAX_SEQ, 32'(limit));
      for (int unsigned k = 0; k < keys; k++) begin
         if (k % 25 == 0) calm = ($urandom_range(0, 2) == 0);
         // hold off until the byte stream is empty now and then
         if ($urandom_range(0, 39) == 0) wait_drained();
         pick_key(usage, mods);
         send_key(usage, mods);
      end
   endtask

   initial begin
      reset                = 1'b1;
      calm                 = 1'b0;
      rsp_hold             = 0;
      cycle_count          = 0;
      config_writes        = 0;
      req_if.valid         = 1'b0;
      req_if.hid_usage     = 8'h00;
      req_if.hid_modifiers = 8'h00;
      rsp_if.ready         = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed keys at reset settings
      send_key(8'h3A, 8'h00);   // f1, ss3
      send_key(8'h45, 8'hFF);   // f12 all modifiers, seven bytes
      send_key(8'h3E, 8'h02);   // f5 left shift
      send_key(8'h49, 8'h00);   // insert, one digit
      send_key(8'h4C, 8'h10);   // delete right ctrl
      send_key(8'h4A, 8'h00);   // home, csi
      send_key(8'h4D, 8'h40);   // end right alt
      send_key(8'h52, 8'h88);   // up, gui only
      send_key(8'h4F, 8'h20);   // right, right shift
      send_key(8'h50, 8'h04);   // left, left alt
      send_key(8'h51, 8'h01);   // down, left ctrl
      send_key(8'h4B, 8'h77);   // page up, every modifier but gui
      send_key(8'h4E, 8'h00);   // page down
      send_key(8'h3D, 8'h05);   // f4 modified
      send_key(8'h00, 8'hFF);   // unknown usages
      send_key(8'hFF, 8'h00);
      send_key(8'h47, 8'h00);   // hole in the table
      send_key(8'h39, 8'h11);
      send_key(8'h53, 8'h22);

      // application cursor mode
      wait_drained();
      csr_write(REG_APP_CURSOR, 32'd1);
      send_key(8'h4A, 8'h00);
      send_key(8'h52, 8'h00);
      send_key(8'h52, 8'h02);
      send_key(8'h3B, 8'h00);

      // random phases over both modes and the length limit extremes
      run_phase(1'b0, 7, PHASE_KEYS);
      run_phase(1'b1, 7, PHASE_KEYS);
      run_phase(1'b0, 3, PHASE_KEYS);
      run_phase(1'b1, 0, PHASE_KEYS);
      run_phase(1'b1, 4, PHASE_KEYS);
      run_phase(1'b0, 5, PHASE_KEYS);
      run_phase(1'b1, 6, PHASE_KEYS);
      run_phase(1'b0, 6, PHASE_KEYS);
      run_phase($urandom_range(0, 1), $urandom_range(0, 7), PHASE_KEYS);
      run_phase(1'b0, 7, PHASE_KEYS);

      wait_drained();
      if (sb.pending_count() != 0) begin
         sb.errors++;
         $display("%0t: %0d bytes never arrived", $time, sb.pending_count());
      end
      $display("covered %0d keys, %0d of them silent, %0d byte beats checked",
               sb.keys_seen, sb.silent_keys, sb.bytes_checked);
      $display("%0d register writes across both cursor modes and limits 0 to 7",
               config_writes);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
